// ===== design/tev_pkg.sv =====
// shared types and constants of the timed event queue
package tev_pkg;

  // most due events handed out by one update item
  localparam int MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DUE      = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    insert;
    logic    pop;
    logic    emit;
    status_t kind;
    logic    last;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/tev_datapath.sv =====
// sorted event register file, due time adder and output register
module tev_datapath #(
  parameter int DEPTH      = 16,
  parameter int TIME_WIDTH = 32,
  parameter int TAG_WIDTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       now_time,
  input  logic [31:0]       delay,
  input  logic [15:0]       tag,
  input  tev_pkg::dp_cmd_t  ctl,
  output tev_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [15:0]       event_tag,
  output logic [31:0]       due_time,
  output logic              last
);
  import tev_pkg::*;

  localparam int TW  = TIME_WIDTH;
  localparam int TGW = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;
  localparam int CW  = $clog2(DEPTH + 1);

  logic [TW-1:0]  entry_time [DEPTH];
  logic [TGW-1:0] entry_tag  [DEPTH];
  logic [CW-1:0]  entry_count;
  logic [TW-1:0]  now_r;
  logic [TW-1:0]  due_r;
  logic [TGW-1:0] tag_r;

  logic [TW:0]    sum;
  logic [TW-1:0]  due_next;

  // per slot: the new event lands at or before this slot
  logic           ins_at    [DEPTH];
  logic           prev_ins  [DEPTH];
  logic [TW-1:0]  prev_time [DEPTH];
  logic [TGW-1:0] prev_tag  [DEPTH];
  logic [TW-1:0]  next_time [DEPTH];
  logic [TGW-1:0] next_tag  [DEPTH];

  assign sum      = {1'b0, TW'(now_time)} + {1'b0, TW'(delay)};
  assign due_next = sum[TW] ? '1 : sum[TW-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : gen_slot
    assign ins_at[i] = (CW'(i) >= entry_count) || (entry_time[i] >= due_r);
    if (i == 0) begin : gen_head
      assign prev_ins[i]  = 1'b0;
      assign prev_time[i] = due_r;
      assign prev_tag[i]  = tag_r;
    end else begin : gen_body
      assign prev_ins[i]  = ins_at[i-1];
      assign prev_time[i] = entry_time[i-1];
      assign prev_tag[i]  = entry_tag[i-1];
    end
    if (i == DEPTH - 1) begin : gen_tail
      assign next_time[i] = entry_time[i];
      assign next_tag[i]  = entry_tag[i];
    end else begin : gen_inner
      assign next_time[i] = entry_time[i+1];
      assign next_tag[i]  = entry_tag[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      now_r <= TW'(now_time);
      due_r <= due_next;
      tag_r <= tag[TGW-1:0];
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (ctl.insert) begin
        if (prev_ins[i]) begin
          entry_time[i] <= prev_time[i];
          entry_tag[i]  <= prev_tag[i];
        end else if (ins_at[i]) begin
          entry_time[i] <= due_r;
          entry_tag[i]  <= tag_r;
        end
      end else if (ctl.pop) begin
        entry_time[i] <= next_time[i];
        entry_tag[i]  <= next_tag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctl.insert) begin
      entry_count <= entry_count + 1'b1;
    end else if (ctl.pop) begin
      entry_count <= entry_count - 1'b1;
    end
  end

  assign stat.full     = (entry_count == CW'(DEPTH));
  assign stat.head_due = (entry_count != '0) && (entry_time[0] <= now_r);
  assign stat.next_due = (entry_count > CW'(1)) && (entry_time[1] <= now_r);
  assign stat.out_free = !out_valid || out_ready;

  // output register: a finished result waits here for the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status <= ctl.kind;
      last   <= ctl.last;
      unique case (ctl.kind)
        ST_ACCEPTED, ST_DROPPED: begin
          event_tag <= '0;
          due_time  <= 32'(due_r);
        end
        ST_DUE: begin
          event_tag <= 16'(entry_tag[0]);
          due_time  <= 32'(entry_time[0]);
        end
        ST_NONE: begin
          event_tag <= '0;
          due_time  <= '0;
        end
      endcase
    end
  end

endmodule

// ===== design/tev_ctrl.sv =====
// control state machine of the timed event queue
module tev_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              cmd,
  output logic              in_ready,
  input  tev_pkg::dp_stat_t stat,
  output tev_pkg::dp_cmd_t  ctl
);
  import tev_pkg::*;

  localparam int NW = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_UPD
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [NW-1:0] sent;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    ctl        = '0;
    ctl.kind   = ST_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = cmd ? S_UPD : S_ADD;
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          ctl.last   = 1'b1;
          ctl.kind   = stat.full ? ST_DROPPED : ST_ACCEPTED;
          ctl.insert = !stat.full;
          state_next = S_IDLE;
        end
      end
      S_UPD: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          if (stat.head_due) begin
            ctl.kind = ST_DUE;
            ctl.pop  = 1'b1;
            // stop when the next slot is not due or the result cap is reached
            ctl.last = !(stat.next_due && (sent != NW'(MAX_RESULTS - 1)));
          end else begin
            ctl.kind = ST_NONE;
            ctl.last = 1'b1;
          end
          if (ctl.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sent  <= '0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        sent <= '0;
      end else if (ctl.pop) begin
        sent <= sent + 1'b1;
      end
    end
  end

endmodule

// ===== design/timed_event_queue.sv =====
// top level of the timed event queue
//
// Holds up to DEPTH pending events sorted by due time. The input channel
// (in_valid/in_ready) takes one item at a time: cmd 0 adds an event due at
// now_time + delay (saturating), cmd 1 dispatches the events due at or
// before now_time, at most MAX_RESULTS per item. The output channel
// (out_valid/out_ready) returns one result for an add (accepted or dropped
// when full), and for an update one result per due event, earliest due time
// first, with last on the final one, or a single none-due result.
// An add item is latched on acceptance and its result is registered in the
// output register once that is free; the next item is taken only after that,
// so the block takes no new item before the last one is through. An update is
// latched, then presents one result per cycle while the output register is
// free. The sorted insert is a single compare-and-shift over all slots, and
// dispatch pops the head slot once per cycle while results are taken.
// A stalled receiver holds the result in the output register and the
// block waits without losing or repeating anything. Reset empties the
// queue, clears the output valid and holds in_ready low; no clearing pass
// is needed.
module timed_event_queue #(
  parameter int DEPTH      = 16,
  parameter int TIME_WIDTH = 32,
  parameter int TAG_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] now_time,
  input  logic [31:0] delay,
  input  logic [15:0] tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] event_tag,
  output logic [31:0] due_time,
  output logic        last
);
  import tev_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  tev_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  tev_datapath #(
    .DEPTH      (DEPTH),
    .TIME_WIDTH (TIME_WIDTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .now_time  (now_time),
    .delay     (delay),
    .tag       (tag),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .event_tag (event_tag),
    .due_time  (due_time),
    .last      (last)
  );

  // never insert into a full queue
  assert property (@(posedge clk) disable iff (rst) ctl.insert |-> !stat.full)
    else $error("insert into full queue");

  // a new result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst) ctl.emit |-> stat.out_free)
    else $error("result overwritten");

  // only a due head slot is popped
  assert property (@(posedge clk) disable iff (rst) ctl.pop |-> stat.head_due)
    else $error("pop of an event not due");

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

endmodule

// ===== dv/timed_event_queue_test.sv =====
// self-checking testbench for the timed event queue: ordered insert, dispatch and drops
`timescale 1ns / 100ps

module timed_event_queue_test;
  import tev_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;
  localparam int ITEM_COUNT = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [31:0] TIME_MAX = 32'hffff_ffff;

  typedef struct {
    status_t     status;
    logic [15:0] tag;
    logic [31:0] due;
    logic        last;
  } outcome_t;

  // mirror of the held events plus the results still owed by the block
  class due_event_tracker;
    logic [31:0] held_time [QUEUE_DEPTH];
    logic [15:0] held_tag [QUEUE_DEPTH];
    int held_count;
    outcome_t owed_results [$];

    function new();
      held_count = 0;
    endfunction

    function void queue_result(status_t st, logic [15:0] t, logic [31:0] due, logic lst);
      outcome_t r;
      r.status = st;
      r.tag = t;
      r.due = due;
      r.last = lst;
      owed_results.push_back(r);
    endfunction

    function void note_item(logic c, logic [31:0] now, logic [31:0] dly, logic [15:0] t);
      logic [32:0] sum;
      logic [31:0] due;
      int pos;
      int n;
      if (c == CMD_ADD) begin
        sum = {1'b0, now} + {1'b0, dly};
        due = sum[32] ? TIME_MAX : sum[31:0];
        if (held_count >= QUEUE_DEPTH) begin
          queue_result(ST_DROPPED, 16'h0, due, 1'b1);
          return;
        end
        // newest goes ahead of any equal due time
        pos = 0;
        while (pos < held_count && held_time[pos] < due) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_time[i] = held_time[i - 1];
          held_tag[i] = held_tag[i - 1];
        end
        held_time[pos] = due;
        held_tag[pos] = t;
        held_count++;
        queue_result(ST_ACCEPTED, 16'h0, due, 1'b1);
      end else begin
        n = 0;
        while (n < held_count && n < MAX_RESULTS && held_time[n] <= now) n++;
        if (n == 0) begin
          queue_result(ST_NONE, 16'h0, 32'h0, 1'b1);
          return;
        end
        for (int i = 0; i < n; i++)
          queue_result(ST_DUE, held_tag[i], held_time[i], i == n - 1);
        for (int i = n; i < held_count; i++) begin
          held_time[i - n] = held_time[i];
          held_tag[i - n] = held_tag[i];
        end
        held_count -= n;
      end
    endfunction

    // empty string when the result matches the oldest owed one
    function string check_result(logic [1:0] st, logic [15:0] t, logic [31:0] due, logic lst);
      outcome_t want;
      string msg;
      if (owed_results.size() == 0)
        return $sformatf("unexpected result: status %0d tag %h due %h last %b", st, t, due, lst);
      want = owed_results.pop_front();
      msg = "";
      if (st !== want.status) msg = {msg, $sformatf(" status %0d/%0d", st, want.status)};
      if (t !== want.tag) msg = {msg, $sformatf(" tag %h/%h", t, want.tag)};
      if (due !== want.due) msg = {msg, $sformatf(" due %h/%h", due, want.due)};
      if (lst !== want.last) msg = {msg, $sformatf(" last %b/%b", lst, want.last)};
      if (msg != "") msg = {"mismatch got/expected:", msg};
      return msg;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [31:0] now_time = 32'h0;
  logic [31:0] delay = 32'h0;
  logic [15:0] tag = 16'h0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [15:0] event_tag;
  logic [31:0] due_time;
  logic last;

  due_event_tracker tracker = new();
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int ready_left = 0;
  logic ready_high = 1'b1;
  logic hold_trigger = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  logic [31:0] tick = 32'h0;

  timed_event_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .now_time(now_time),
    .delay(delay),
    .tag(tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .event_tag(event_tag),
    .due_time(due_time),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string msg);
    errors++;
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // bursts of back-to-back items with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_item(input logic c, input logic [31:0] now, input logic [31:0] dly,
                           input logic [15:0] t);
    in_valid <= 1'b1;
    cmd <= c;
    now_time <= now;
    delay <= dly;
    tag <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_item(c, now, dly, t);
    pace_sender();
  endtask

  // long receiver hold-off, started by flipping hold_trigger
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && out_ready) begin
      msg = tracker.check_result(status, event_tag, due_time, last);
      if (msg != "") report(msg);
    end
    if (ready_left == 0) begin
      ready_high = $urandom_range(0, 3) != 0;
      ready_left = ready_high ? $urandom_range(1, 30) : $urandom_range(1, 8);
    end else begin
      ready_left--;
    end
    out_ready <= ready_high && (hold_left == 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed_event_queue test failed");
      $finish;
    end
  end

  initial begin
    int pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, zero and saturated due times, equal due times
    send_item(CMD_UPDATE, 32'h0, 32'h0, 16'h0);
    send_item(CMD_ADD, 32'h0, 32'h0, 16'h0);
    send_item(CMD_ADD, TIME_MAX, TIME_MAX, 16'hffff);
    send_item(CMD_ADD, 32'd100, 32'd0, 16'h0001);
    send_item(CMD_ADD, 32'd50, 32'd50, 16'h0002);
    send_item(CMD_UPDATE, 32'd100, 32'h0, 16'h0);
    send_item(CMD_UPDATE, TIME_MAX - 1, 32'h0, 16'h0);
    send_item(CMD_UPDATE, TIME_MAX, 32'h0, 16'h0);
    // fill with falling due times so each lands at the front, then overflow
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_item(CMD_ADD, 32'h0, 32'd1000 - 32'(i * 10), 16'(i));
    send_item(CMD_ADD, 32'd5, 32'd5, 16'h5a5a);
    send_item(CMD_UPDATE, TIME_MAX, 32'h0, 16'h0);

    hold_trigger <= ~hold_trigger;
    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (n == ITEM_COUNT / 2) hold_trigger <= ~hold_trigger;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        case ($urandom_range(0, 9))
          0: send_item(CMD_ADD, tick, $urandom, 16'($urandom));
          1: send_item(CMD_ADD, tick, $urandom_range(0, 2000), 16'($urandom));
          default: send_item(CMD_ADD, tick, $urandom_range(0, 40), 16'($urandom));
        endcase
      end else if (pick < 88) begin
        tick = tick + $urandom_range(0, 40);
        send_item(CMD_UPDATE, tick, $urandom, 16'($urandom));
      end else if (pick < 96) begin
        // noise over the full field ranges
        send_item(1'($urandom), $urandom, $urandom, 16'($urandom));
      end else begin
        // flush whatever is left, saturated times included
        send_item(CMD_UPDATE, TIME_MAX, $urandom, 16'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("timed_event_queue test passed");
    else
      $display("timed_event_queue test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tev_pkg.sv
design/tev_datapath.sv
design/tev_ctrl.sv
design/timed_event_queue.sv
dv/timed_event_queue_test.sv
